// ===== sv/assert_macros.svh =====
// assertion macros used by the rtl top
// expects clk and rst in the scope of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/evts_pkg.sv =====
// package for the eight voice tone synth: codes, widths, voice state type
// and small helper functions; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package evts_pkg;

  localparam int MAX_VOICES = 8;
  localparam int REG_ADDR_W = 5;
  localparam int REG_COUNT  = 32;
  localparam int PERIOD_W   = 11;
  localparam int SHIFT_W    = 15;
  localparam int STUB_W     = 7;
  localparam int DIV_NUM_W  = 19;
  localparam int DIV_CNT_W  = 5;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  localparam logic [1:0] WAVE_PULSE = 2'd0;
  localparam logic [1:0] WAVE_TRI   = 2'd1;
  localparam logic [1:0] WAVE_NOISE = 2'd2;
  localparam logic [1:0] WAVE_STUB  = 2'd3;

  localparam logic [1:0] DUTY_EIGHTH  = 2'd0;
  localparam logic [1:0] DUTY_QUARTER = 2'd1;
  localparam logic [1:0] DUTY_3QUART  = 2'd3;

  // floor(m / 15) == (m * 2185) >> 15 for m below 2048
  localparam logic [11:0] VOL_RECIP       = 12'd2185;
  localparam int          VOL_RECIP_SHIFT = 15;

  typedef struct packed {
    logic [PERIOD_W-1:0]      phase;
    logic [SHIFT_W-1:0]       shift;
    logic signed [STUB_W-1:0] stub;
  } voice_state_t;

  localparam voice_state_t VOICE_RESET = '{phase: '0, shift: 15'd1, stub: '0};

  function automatic logic [PERIOD_W-1:0] duty_threshold(input logic [PERIOD_W-1:0] p,
                                                         input logic [1:0] duty);
    logic [PERIOD_W+1:0] p3;
    p3 = {2'b00, p} + {1'b0, p, 1'b0};
    case (duty)
      DUTY_EIGHTH:  duty_threshold = p >> 3;
      DUTY_QUARTER: duty_threshold = p >> 2;
      DUTY_3QUART:  duty_threshold = p3[PERIOD_W+1:2];
      default:      duty_threshold = p >> 1;
    endcase
  endfunction

  function automatic logic [SHIFT_W-1:0] lfsr_step(input logic [SHIFT_W-1:0] s);
    logic [SHIFT_W-1:0] l;
    l = (s == '0) ? SHIFT_W'(1) : s;
    lfsr_step = {l[0] ^ l[1], l[SHIFT_W-1:1]};
  endfunction

endpackage

`default_nettype wire

// ===== sv/evts_ifs.sv =====
// valid/ready channel interfaces for command and result beats
// depends on evts_pkg
`timescale 1ns / 1ps
`default_nettype none

interface evts_cmd_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    operation;
  logic [evts_pkg::REG_ADDR_W-1:0] reg_addr;
  logic [7:0]                    write_data;
  modport source (output valid, operation, reg_addr, write_data, input ready);
  modport sink (input valid, operation, reg_addr, write_data, output ready);
endinterface

interface evts_res_if;
  logic        valid;
  logic        ready;
  logic [7:0]  read_data;
  logic [7:0]  mix_sample;
  logic        pwm_high;
  logic [31:0] pwm_edge_count;
  logic [31:0] pwm_high_ticks;
  modport source (output valid, read_data, mix_sample, pwm_high, pwm_edge_count,
                  pwm_high_ticks, input ready);
  modport sink (input valid, read_data, mix_sample, pwm_high, pwm_edge_count,
                pwm_high_ticks, output ready);
endinterface

`default_nettype wire

// ===== sv/eight_voice_tone_synth_regs_top.sv =====
// write or unused op: result beat registered in S_DONE; a read first passes S_RDWAIT
// tick: fetch and check each voice; an active voice divides its phase, then
// divides (triangle) or scales, then the mix divides; one shared 19-step divider
// one item in flight; next command taken while a result beat still waits
// reset: register bytes read zero, voice state back to phase 0, noise 1, stub 0
`timescale 1ns / 1ps
`default_nettype none

module eight_voice_tone_synth_regs_top #(
  parameter int VOICES = evts_pkg::MAX_VOICES
) (
  input logic        clk,
  input logic        rst,
  evts_cmd_if.sink   cmd,
  evts_res_if.source res
);
  import evts_pkg::*;

  `include "assert_macros.svh"

  localparam int         VSW        = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam logic [2:0] LAST_VOICE = 3'(VOICES - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_RDWAIT, S_FETCH, S_CHECK, S_MODW, S_WAVE, S_TRIW,
    S_SCALE, S_SCALE2, S_ACC, S_MIX, S_MIXW, S_PWM, S_DONE
  } state_t;

  state_t state;

  // register file memory
  logic [7:0]          rf_mem [REG_COUNT];
  logic [REG_COUNT-1:0] rf_valid;
  logic [REG_ADDR_W-1:0] rf_raddr;
  logic [7:0]          rf_q;
  logic                rf_vq;
  logic                rf_we;
  logic [7:0]          rf_byte;

  // voice state memory
  voice_state_t        vs_mem [VOICES];
  logic [VOICES-1:0]   vs_valid;
  voice_state_t        vs_q;
  logic                vs_vq;
  logic                vs_we;
  voice_state_t        vs_cur;

  logic accept;

  // sequencing
  logic [2:0]  voice;
  logic [2:0]  fcnt;
  logic [1:0]  cur_op;
  logic [7:0]  rd_hold;
  logic [7:0]  ctrl_b, perl_b, perh_b, wave_b;
  voice_state_t vstate;
  logic [PERIOD_W-1:0] phase_new;
  logic        tri_lo;
  logic signed [8:0]  amp;
  logic signed [8:0]  amp_s;
  logic [10:0] vprod;
  logic signed [11:0] acc;
  logic [3:0]  cnt_act;
  logic        mix_neg;
  logic        pwm_cand;
  logic        pwm_last;
  logic [7:0]  last_mix;
  logic [31:0] edge_cnt;
  logic [31:0] high_cnt;

  // shared restoring divider
  logic [DIV_NUM_W-1:0] dv_num;
  logic [PERIOD_W-1:0]  dv_rem;
  logic [PERIOD_W-1:0]  dv_den;
  logic [DIV_CNT_W-1:0] dv_cnt;
  logic [PERIOD_W:0]    dv_trial;
  logic [PERIOD_W:0]    dv_diff;
  logic                 dv_ge;

  // decoded voice fields
  logic                en;
  logic [3:0]          vol;
  logic [PERIOD_W-1:0] period;
  logic [1:0]          duty;
  logic [1:0]          wave;
  logic [PERIOD_W-1:0] half;
  logic                pulse_hi;
  logic [PERIOD_W-1:0] tri_x;
  logic signed [7:0]   lv_sum;
  logic signed [STUB_W-1:0] lv_new;
  logic [SHIFT_W-1:0]  nsh_new;
  logic [7:0]          amp_mag;
  logic [22:0]         qprod;
  logic [7:0]          q15;
  logic [11:0]         acc_mag;
  logic signed [11:0]  avg;
  logic [7:0]          mix_byte;
  logic [7:0]          tri_q;

  assign accept    = cmd.valid && cmd.ready;
  assign cmd.ready = (state == S_IDLE);
  assign rf_we     = accept && (cmd.operation == OP_WRITE);
  assign rf_raddr  = (state == S_FETCH) ? {voice, fcnt[1:0]} : cmd.reg_addr;
  assign rf_byte   = rf_vq ? rf_q : 8'd0;
  assign vs_we     = (state == S_ACC);
  assign vs_cur    = vs_vq ? vs_q : VOICE_RESET;

  assign en       = ctrl_b[0];
  assign vol      = ctrl_b[7:4];
  assign period   = {perh_b[2:0], perl_b};
  assign duty     = perh_b[5:4];
  assign wave     = wave_b[1:0];
  assign half     = period >> 1;
  assign pulse_hi = phase_new < duty_threshold(period, duty);
  assign tri_x    = (phase_new < half) ? phase_new : (phase_new - half);
  assign lv_sum   = 8'(vstate.stub) + ((phase_new == '0) ? 8'sd2 :
                    ((phase_new == half) ? -8'sd2 : 8'sd0));
  assign lv_new   = (lv_sum > 8'sd63) ? 7'sd63 :
                    ((lv_sum < -8'sd64) ? -7'sd64 : lv_sum[STUB_W-1:0]);
  assign nsh_new  = (phase_new == '0) ? lfsr_step(vstate.shift) : vstate.shift;
  assign amp_mag  = amp[8] ? 8'(-amp) : amp[7:0];
  assign qprod    = 23'(vprod) * 23'(VOL_RECIP);
  assign q15      = qprod[VOL_RECIP_SHIFT +: 8];
  assign acc_mag  = acc[11] ? 12'(-acc) : 12'(acc);
  assign avg      = mix_neg ? -12'(dv_num) : 12'(dv_num);
  assign mix_byte = (avg > 12'sd127) ? 8'd255 :
                    ((avg < -12'sd128) ? 8'd0 : (avg[7:0] ^ 8'h80));
  assign tri_q    = dv_num[7:0];

  assign dv_trial = {dv_rem, dv_num[DIV_NUM_W-1]};
  assign dv_diff  = dv_trial - {1'b0, dv_den};
  assign dv_ge    = dv_trial >= {1'b0, dv_den};

  always_ff @(posedge clk) begin
    if (rf_we) begin
      rf_mem[cmd.reg_addr] <= cmd.write_data;
    end
    rf_q <= rf_mem[rf_raddr];
    rf_vq <= rf_valid[rf_raddr];
    if (vs_we) begin
      vs_mem[voice[VSW-1:0]] <= '{phase: phase_new, shift: vstate.shift, stub: vstate.stub};
    end
    vs_q <= vs_mem[voice[VSW-1:0]];
    vs_vq <= vs_valid[voice[VSW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rf_valid <= '0;
      vs_valid <= '0;
    end else begin
      if (rf_we) begin
        rf_valid[cmd.reg_addr] <= 1'b1;
      end
      if (vs_we) begin
        vs_valid[voice[VSW-1:0]] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      dv_cnt    <= '0;
      last_mix  <= 8'd128;
      pwm_last  <= 1'b0;
      edge_cnt  <= '0;
      high_cnt  <= '0;
      res.valid <= 1'b0;
      voice     <= '0;
      fcnt      <= '0;
      cnt_act   <= '0;
      cur_op    <= OP_WRITE;
    end else begin
      if (res.valid && res.ready && (state != S_DONE)) begin
        res.valid <= 1'b0;
      end
      if (dv_cnt != '0) begin
        dv_rem <= dv_ge ? dv_diff[PERIOD_W-1:0] : dv_trial[PERIOD_W-1:0];
        dv_num <= {dv_num[DIV_NUM_W-2:0], dv_ge};
        dv_cnt <= dv_cnt - 1'b1;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            cur_op <= cmd.operation;
            rd_hold <= 8'd0;
            case (cmd.operation)
              OP_READ: state <= S_RDWAIT;
              OP_TICK: begin
                voice <= '0;
                fcnt <= '0;
                acc <= '0;
                cnt_act <= '0;
                pwm_cand <= 1'b0;
                state <= S_FETCH;
              end
              default: state <= S_DONE;
            endcase
          end
        end
        S_RDWAIT: begin
          rd_hold <= rf_byte;
          state <= S_DONE;
        end
        S_FETCH: begin
          fcnt <= fcnt + 1'b1;
          case (fcnt)
            3'd1: ctrl_b <= rf_byte;
            3'd2: perl_b <= rf_byte;
            3'd3: perh_b <= rf_byte;
            3'd4: begin
              wave_b <= rf_byte;
              vstate <= vs_cur;
              state <= S_CHECK;
            end
            default: ;
          endcase
        end
        S_CHECK: begin
          if (en && (period >= PERIOD_W'(2))) begin
            dv_num <= DIV_NUM_W'(vstate.phase) + 1'b1;
            dv_rem <= '0;
            dv_den <= period;
            dv_cnt <= DIV_CNT_W'(DIV_NUM_W);
            state <= S_MODW;
          end else if (voice == LAST_VOICE) begin
            state <= S_MIX;
          end else begin
            voice <= voice + 1'b1;
            fcnt <= '0;
            state <= S_FETCH;
          end
        end
        S_MODW: begin
          if (dv_cnt == '0) begin
            phase_new <= dv_rem;
            state <= S_WAVE;
          end
        end
        S_WAVE: begin
          if (voice == '0) begin
            pwm_cand <= pulse_hi && (vol != '0);
          end
          state <= S_SCALE;
          case (wave)
            WAVE_TRI: begin
              tri_lo <= phase_new < half;
              dv_num <= DIV_NUM_W'(tri_x) * DIV_NUM_W'(255);
              dv_rem <= '0;
              dv_den <= half;
              dv_cnt <= DIV_CNT_W'(DIV_NUM_W);
              state <= S_TRIW;
            end
            WAVE_NOISE: begin
              vstate.shift <= nsh_new;
              amp <= nsh_new[0] ? 9'sd127 : -9'sd128;
            end
            WAVE_STUB: begin
              vstate.stub <= lv_new;
              amp <= 9'(lv_new) <<< 1;
            end
            default: amp <= pulse_hi ? 9'sd127 : -9'sd128;
          endcase
        end
        S_TRIW: begin
          if (dv_cnt == '0) begin
            amp_s <= tri_lo ? ($signed({1'b0, tri_q}) - 9'sd128)
                            : (9'sd127 - $signed({1'b0, tri_q}));
            state <= S_ACC;
          end
        end
        S_SCALE: begin
          vprod <= 11'(amp_mag) * 11'(vol);
          state <= S_SCALE2;
        end
        S_SCALE2: begin
          amp_s <= amp[8] ? -9'(q15) : 9'(q15);
          state <= S_ACC;
        end
        S_ACC: begin
          acc <= acc + 12'(amp_s);
          cnt_act <= cnt_act + 1'b1;
          if (voice == LAST_VOICE) begin
            state <= S_MIX;
          end else begin
            voice <= voice + 1'b1;
            fcnt <= '0;
            state <= S_FETCH;
          end
        end
        S_MIX: begin
          if (cnt_act == '0) begin
            last_mix <= 8'd128;
            state <= S_PWM;
          end else begin
            mix_neg <= acc[11];
            dv_num <= DIV_NUM_W'(acc_mag);
            dv_rem <= '0;
            dv_den <= PERIOD_W'(cnt_act);
            dv_cnt <= DIV_CNT_W'(DIV_NUM_W);
            state <= S_MIXW;
          end
        end
        S_MIXW: begin
          if (dv_cnt == '0) begin
            last_mix <= mix_byte;
            state <= S_PWM;
          end
        end
        S_PWM: begin
          pwm_last <= pwm_cand;
          if (pwm_cand != pwm_last) begin
            edge_cnt <= edge_cnt + 1'b1;
          end
          if (pwm_cand) begin
            high_cnt <= high_cnt + 1'b1;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (!res.valid || res.ready) begin
            res.valid <= 1'b1;
            res.read_data <= rd_hold;
            res.mix_sample <= last_mix;
            res.pwm_high <= pwm_last;
            res.pwm_edge_count <= edge_cnt;
            res.pwm_high_ticks <= high_cnt;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ASSERT_IMPLY(a_mod_rem, (state == S_MODW) && (dv_cnt == '0), dv_rem < dv_den, "phase not below period")
  `ASSERT_IMPLY(a_act_cnt, state == S_ACC, {1'b0, voice} >= cnt_act, "active count exceeds voices seen")
  `ASSERT_NEXT(a_edge, state == S_PWM, edge_cnt == $past(edge_cnt) + 32'(pwm_last != $past(pwm_last)), "edge count off")
  `ASSERT_IMPLY(a_rd_zero, (state == S_DONE) && (cur_op != OP_READ), rd_hold == 8'd0, "read data on non-read")

endmodule

`default_nettype wire
